[hw/rtl/csvt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types, character codes and the step function for bytes outside
// quotes, for the CSV line tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned MAX_FIELDS = 1023;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned CAP_INT    = (MAX_FIELDS < 1023) ? MAX_FIELDS : 1023;
  localparam logic [CNT_W-1:0] COUNT_CAP = CAP_INT[CNT_W-1:0];

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [4:0] {
    MODE_START   = 5'b00001,
    MODE_PLAIN   = 5'b00010,
    MODE_QUOTED  = 5'b00100,
    MODE_PENDING = 5'b01000,
    MODE_SKIP    = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  emit;
    logic  end_field;
  } step_t;

  typedef struct packed {
    logic [7:0]       char_out;
    logic             has_char;
    logic             field_end;
    logic             line_end;
    logic [CNT_W-1:0] field_count;
  } res_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  // byte outside quotes; at_start allows an opening quote
  function automatic step_t plain_step(input logic [7:0] c, input logic at_start);
    step_t s;
    s.mode      = MODE_PLAIN;
    s.emit      = 1'b0;
    s.end_field = 1'b0;
    if (at_start && (c == CH_QUOTE)) begin
      s.mode = MODE_QUOTED;
    end else if (c == CH_COMMA) begin
      s.end_field = 1'b1;
      s.mode      = MODE_START;
    end else if (is_eol(c)) begin
      s.end_field = 1'b1;
      s.mode      = MODE_SKIP;
    end else begin
      s.emit = 1'b1;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/csv_line_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csv_line_tokenizer
// Streaming CSV field splitter: one byte in, one result out.
// Each byte passes the input register, then the result register; the parse
// step between the two registers is combinational. Throughput: one byte per
// cycle while the consumer holds out_ready high.
// Reset (rst_n, synchronous): both stages empty, field start, count zero.
// ----------------------------------------------------------------------------
module csv_line_tokenizer
  import csvt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_char_in,
  input  wire logic             in_line_last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_char_out,
  output logic                  out_has_char,
  output logic                  out_field_end,
  output logic                  out_line_end,
  output logic [CNT_W-1:0]      out_field_count
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       can_load;
  logic       advance;
  res_t       res_c;
  res_t       res_q;

  assign advance      = s1_valid_r && can_load;
  assign in_ready     = !s1_valid_r || can_load;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_line_last;
    end
  end

  csvt_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .char_in   (s1_char_r),
    .line_last (s1_last_r),
    .res       (res_c)
  );

  csvt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (res_c),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_char_out    = res_q.char_out;
  assign out_has_char    = res_q.has_char;
  assign out_field_end   = res_q.field_end;
  assign out_line_end    = res_q.line_end;
  assign out_field_count = res_q.field_count;

endmodule
`default_nettype wire

[hw/rtl/csvt_parse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_parse
// Parse state and field counter; computes one result per byte and advances
// the state when the byte moves on to the result register.
// ----------------------------------------------------------------------------
module csvt_parse
  import csvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic [7:0] char_in,
  input  wire logic       line_last,
  output res_t            res
);

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] fields_r, fields_nxt;
  step_t            st;
  logic             end_f;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    st.mode      = mode_r;
    st.emit      = 1'b0;
    st.end_field = 1'b0;
    unique case (mode_r)
      MODE_QUOTED: begin
        if (char_in == CH_QUOTE) begin
          st.mode = MODE_PENDING;
        end else begin
          st.emit = 1'b1;
        end
      end
      MODE_PENDING: begin
        if (char_in == CH_QUOTE) begin
          st.emit = 1'b1;
          st.mode = MODE_QUOTED;
        end else begin
          st = plain_step(char_in, 1'b0);
        end
      end
      MODE_SKIP: begin
        if (!is_eol(char_in)) begin
          st = plain_step(char_in, 1'b1);
        end
      end
      MODE_PLAIN: st = plain_step(char_in, 1'b0);
      MODE_START: st = plain_step(char_in, 1'b1);
      default:    st = plain_step(char_in, 1'b1);
    endcase
  end

  // an open field closes at end of line
  assign end_f = st.end_field ||
                 (line_last && ((st.mode == MODE_PLAIN) || (st.mode == MODE_QUOTED) ||
                                (st.mode == MODE_PENDING)));

  assign cnt = (end_f && (fields_r < COUNT_CAP)) ? fields_r + 1'b1 : fields_r;

  assign mode_nxt   = line_last ? MODE_START : st.mode;
  assign fields_nxt = line_last ? '0 : cnt;

  assign res.char_out    = st.emit ? char_in : 8'h00;
  assign res.has_char    = st.emit;
  assign res.field_end   = end_f;
  assign res.line_end    = line_last;
  assign res.field_count = cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_START;
      fields_r <= '0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      fields_r <= fields_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/csvt_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_out_stage
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module csvt_out_stage
  import csvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
`default_nettype wire

[tb/sv/csv_token_checker.sv]
// ----------------------------------------------------------------------------
// csv_token_checker
// Watches both channels of the CSV line tokenizer, predicts the result of
// every accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module csv_token_checker
  import csvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_char_in,
  input  logic             in_line_last,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [7:0]       out_char_out,
  input  logic             out_has_char,
  input  logic             out_field_end,
  input  logic             out_line_end,
  input  logic [CNT_W-1:0] out_field_count,
  output int               errors,
  output int               waiting
);

  res_t             token_q[$];
  mode_t            tok_mode;
  logic [CNT_W-1:0] tok_count;

  function automatic res_t predict_token(input logic [7:0] c, input logic last);
    res_t r;
    logic outside;
    logic may_open;
    r        = '0;
    outside  = 1'b0;
    may_open = 1'b0;
    case (tok_mode)
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          tok_mode = MODE_PENDING;
        end else begin
          r.has_char = 1'b1;
          r.char_out = c;
        end
      end
      MODE_PENDING: begin
        if (c == CH_QUOTE) begin
          r.has_char = 1'b1;
          r.char_out = CH_QUOTE;
          tok_mode   = MODE_QUOTED;
        end else begin
          outside = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (c != CH_CR && c != CH_LF) begin
          outside  = 1'b1;
          may_open = 1'b1;
        end
      end
      MODE_PLAIN: begin
        outside = 1'b1;
      end
      default: begin
        outside  = 1'b1;
        may_open = 1'b1;
      end
    endcase
    if (outside) begin
      if (may_open && c == CH_QUOTE) begin
        tok_mode = MODE_QUOTED;
      end else if (c == CH_COMMA) begin
        r.field_end = 1'b1;
        tok_mode    = MODE_START;
      end else if (c == CH_CR || c == CH_LF) begin
        r.field_end = 1'b1;
        tok_mode    = MODE_SKIP;
      end else begin
        r.has_char = 1'b1;
        r.char_out = c;
        tok_mode   = MODE_PLAIN;
      end
    end
    // open field is closed by the end of the line
    if (last && (tok_mode == MODE_PLAIN || tok_mode == MODE_QUOTED ||
                 tok_mode == MODE_PENDING)) begin
      r.field_end = 1'b1;
    end
    if (r.field_end && tok_count < COUNT_CAP) begin
      tok_count = tok_count + 1'b1;
    end
    r.line_end    = last;
    r.field_count = tok_count;
    if (last) begin
      tok_mode  = MODE_START;
      tok_count = '0;
    end
    return r;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      tok_mode  = MODE_START;
      tok_count = '0;
      errors    = 0;
      token_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          report($sformatf("result with nothing expected, char_out %0h", out_char_out));
        end else begin
          want = token_q.pop_front();
          check_field("char_out", 16'(out_char_out), 16'(want.char_out));
          check_field("has_char", 16'(out_has_char), 16'(want.has_char));
          check_field("field_end", 16'(out_field_end), 16'(want.field_end));
          check_field("line_end", 16'(out_line_end), 16'(want.line_end));
          check_field("field_count", 16'(out_field_count), 16'(want.field_count));
        end
      end
      // request accepted
      if (in_valid && in_ready) begin
        token_q.push_back(predict_token(in_char_in, in_line_last));
      end
    end
    waiting <= token_q.size();
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the CSV line tokenizer with directed and random lines under
// varying sender gaps and receiver stalls; the checker scores the results.
// ----------------------------------------------------------------------------
module tb;
  import csvt_pkg::*;

  localparam int LIMIT = 200000;
  localparam int HOLD  = 70;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic [7:0]       in_char_in   = 8'h01;
  logic             in_line_last = 1'b0;
  logic             out_ready    = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [7:0]       out_char_out;
  logic             out_has_char;
  logic             out_field_end;
  logic             out_line_end;
  logic [CNT_W-1:0] out_field_count;

  int mismatches;
  int outstanding;
  int cycles      = 0;
  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int bytes_sent  = 0;

  logic [7:0] line_buf[$];

  always #6 clk = ~clk;

  csv_line_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .in_line_last    (in_line_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_has_char    (out_has_char),
    .out_field_end   (out_field_end),
    .out_line_end    (out_line_end),
    .out_field_count (out_field_count)
  );

  csv_token_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .in_line_last    (in_line_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_has_char    (out_has_char),
    .out_field_end   (out_field_end),
    .out_line_end    (out_line_end),
    .out_field_count (out_field_count),
    .errors          (mismatches),
    .waiting         (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255, 1));
    end while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] eol_byte();
    return $urandom_range(1) ? CH_CR : CH_LF;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_in   <= c;
    in_line_last <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic random_line();
    int nf;
    int kind;
    line_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12, 1)) line_buf.push_back(8'($urandom_range(255, 1)));
    end else begin
      nf = $urandom_range(5, 1);
      for (int f = 0; f < nf; f++) begin
        kind = $urandom_range(9);
        if (kind < 4) begin
          repeat ($urandom_range(6)) line_buf.push_back(data_byte());
        end else if (kind < 8) begin
          line_buf.push_back(CH_QUOTE);
          repeat ($urandom_range(6)) begin
            case ($urandom_range(5))
              0: line_buf.push_back(CH_COMMA);
              1: line_buf.push_back(eol_byte());
              2: begin
                line_buf.push_back(CH_QUOTE);
                line_buf.push_back(CH_QUOTE);
              end
              default: line_buf.push_back(data_byte());
            endcase
          end
          // unterminated quote only on the last field
          if (!(f == nf - 1 && $urandom_range(3) == 0)) begin
            line_buf.push_back(CH_QUOTE);
            if (kind == 7) line_buf.push_back(data_byte());
          end
        end else if (kind == 8) begin
          repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom_range(255, 1)));
        end
        if (f < nf - 1) begin
          if ($urandom_range(3) != 0) begin
            line_buf.push_back(CH_COMMA);
          end else begin
            repeat ($urandom_range(3, 1)) line_buf.push_back(eol_byte());
          end
        end
      end
      case ($urandom_range(5))
        0: line_buf.push_back(CH_COMMA);
        1: begin
          line_buf.push_back(CH_CR);
          line_buf.push_back(CH_LF);
        end
        default: ;
      endcase
    end
    if (line_buf.size() == 0) line_buf.push_back(data_byte());
    send_line();
  endtask

  task automatic random_phase(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) random_line();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 22;
    recv_idle = 62;
    // plain, quoted with doubled quote, trailing comma
    line_buf = {8'h61, CH_COMMA, CH_QUOTE, 8'h62, CH_QUOTE, CH_QUOTE, 8'h63,
                CH_QUOTE, CH_COMMA};
    send_line();
    // empty fields, skipped LF, mid-field quote
    line_buf = {CH_COMMA, CH_CR, CH_LF, 8'h7A, CH_QUOTE};
    send_line();
    // unterminated quote with byte extremes
    line_buf = {CH_QUOTE, 8'hFF, CH_COMMA, 8'h01};
    send_line();
    // line ends on a pending quote
    line_buf = {CH_QUOTE, CH_QUOTE};
    send_line();
    // byte after a closing quote, line ends in skip
    line_buf = {CH_QUOTE, 8'h71, CH_QUOTE, 8'h72, CH_CR};
    send_line();
    random_phase(180);

    send_idle = 62;
    recv_idle = 22;
    hold_reqs++;
    random_phase(180);

    send_idle = 0;
    recv_idle = 0;
    hold_reqs++;
    random_phase(190);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
